FILE: rtl/core/lkvc_pkg.sv
// lkvc_pkg: shared constants and types for the lru key-value cache core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = IdxW + 1;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CapW    = 5;
  localparam logic        OpGet   = 1'b0;
  localparam logic        OpPut   = 1'b1;
  localparam logic [ValW-1:0] MissValue = '1;

  typedef struct packed {
    logic            found;
    logic [ValW-1:0] value;
  } result_t;
endpackage
`default_nettype wire

FILE: rtl/core/lru_key_value_cache_core.sv
// lru_key_value_cache_core: top level of the lru key-value cache
// depends on lkvc_pkg; holds key, value and rank memories and the sequencer
//
// usage: one input beat (opcode, lookup_key, write_value) on in_valid_i/in_stall_o
// gives exactly one output beat (key_found_o, read_value_o) on out_valid_o/out_stall_i.
// a get returns the stored value on a hit, all ones otherwise; a put always returns
// all ones with key_found_o telling whether the key was present.
// sequence: the sequencer scans the slots in use, one memory read per cycle, then
// makes a second scan to update ranks and write back; a get that misses skips the
// second scan. one item is in work at a time: a new beat is taken only once the
// sequencer is back in idle.
// the result sits in an output register; the next beat is taken as soon as the
// sequencer is idle, even while the result is stalled, but a new result waits
// until the old one is taken.
// reset clears the fill count and sets capacity to 16; memory contents are
// undefined and are never read before written. cfg_we_i writes the capacity.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [lkvc_pkg::CapW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      opcode_i,
  input  wire logic [lkvc_pkg::KeyW-1:0] lookup_key_i,
  input  wire logic [lkvc_pkg::ValW-1:0] write_value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           key_found_o,
  output logic [lkvc_pkg::ValW-1:0]      read_value_o
);
  localparam int unsigned IdxW = lkvc_pkg::IdxW;
  localparam int unsigned CntW = lkvc_pkg::CntW;

  typedef enum logic [2:0] {
    StIdle, StScan, StRank, StWrite, StDone
  } state_e;

  state_e state_q;
  logic [lkvc_pkg::CapW-1:0] cap_q;
  logic [CntW-1:0] fill_q, idx_q;
  logic            op_q;
  logic [lkvc_pkg::KeyW-1:0] key_q;
  logic [lkvc_pkg::ValW-1:0] val_q;
  logic [lkvc_pkg::ValW-1:0] hval_q;  // value of the hit slot
  logic            found_q;
  logic [IdxW-1:0] hit_q, lru_q, tgt_q;
  logic [IdxW-1:0] rank_q;          // old rank of target
  logic            insert_q;        // new slot appended
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            out_valid_q;
  lkvc_pkg::result_t res_q;

  // memories
  logic [lkvc_pkg::KeyW-1:0] key_mem [lkvc_pkg::Entries];
  logic [lkvc_pkg::ValW-1:0] val_mem [lkvc_pkg::Entries];
  logic [IdxW-1:0]           rnk_mem [lkvc_pkg::Entries];
  logic [lkvc_pkg::KeyW-1:0] key_rd_q;
  logic [lkvc_pkg::ValW-1:0] val_rd_q;
  logic [IdxW-1:0]           rnk_rd_q;

  logic            rd_en, kv_we, rk_we;
  logic [IdxW-1:0] rd_addr, kv_addr, rk_addr, rk_wdata;

  logic [CntW-1:0] cap_eff;
  always_comb begin
    cap_eff = cap_q[CntW-1:0];
    if (cap_q == '0) cap_eff = CntW'(1);
    if (cap_q > lkvc_pkg::CapW'(lkvc_pkg::Entries)) cap_eff = CntW'(lkvc_pkg::Entries);
  end

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // result register loads when empty or being drained
  logic out_load;
  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // scan: read slot idx_q while idx_q < fill_q
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx_q[IdxW-1:0];
    kv_we    = 1'b0;
    kv_addr  = tgt_q;
    rk_we    = 1'b0;
    rk_addr  = rd_idx_q;
    rk_wdata = rnk_rd_q;
    unique case (state_q)
      StScan, StRank: rd_en = (idx_q < fill_q);
      StWrite: begin
        kv_we    = (op_q == lkvc_pkg::OpPut);
        rk_we    = 1'b1;
        rk_addr  = tgt_q;
        rk_wdata = '0;
      end
      default: ;
    endcase
    // rank aging during second scan
    if (state_q == StRank && rd_vld_q &&
        (insert_q || rnk_rd_q < rank_q)) begin
      rk_we    = 1'b1;
      rk_wdata = rnk_rd_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      val_rd_q <= val_mem[rd_addr];
      rnk_rd_q <= rnk_mem[rd_addr];
    end
    if (kv_we) begin
      key_mem[kv_addr] <= key_q;
      val_mem[kv_addr] <= val_q;
    end
    if (rk_we) rnk_mem[rk_addr] <= rk_wdata;
  end

  logic [CntW-1:0] fill_m1;
  assign fill_m1 = fill_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= lkvc_pkg::CapW'(lkvc_pkg::Entries);
      fill_q      <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      insert_q    <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      rd_vld_q <= rd_en;
      rd_idx_q <= rd_addr;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            op_q     <= opcode_i;
            key_q    <= lookup_key_i;
            val_q    <= write_value_i;
            found_q  <= 1'b0;
            insert_q <= 1'b0;
            idx_q    <= '0;
            state_q  <= StScan;
          end
        end
        StScan: begin
          if (rd_en) idx_q <= idx_q + CntW'(1);
          if (rd_vld_q) begin
            if (!found_q && key_rd_q == key_q) begin
              found_q <= 1'b1;
              hit_q   <= rd_idx_q;
              rank_q  <= rnk_rd_q;
              hval_q  <= val_rd_q;
            end
            if (rnk_rd_q[IdxW-1:0] == fill_m1[IdxW-1:0]) lru_q <= rd_idx_q;
          end
          if (!rd_en && !rd_vld_q) begin
            idx_q <= '0;
            if (found_q) begin
              tgt_q   <= hit_q;
              state_q <= StRank;
            end else if (op_q == lkvc_pkg::OpGet) begin
              state_q <= StDone;
            end else if (fill_q >= cap_eff) begin
              tgt_q   <= lru_q;
              rank_q  <= fill_m1[IdxW-1:0];
              state_q <= StRank;
            end else begin
              tgt_q    <= fill_q[IdxW-1:0];
              insert_q <= 1'b1;
              state_q  <= StRank;
            end
          end
        end
        StRank: begin
          if (rd_en) idx_q <= idx_q + CntW'(1);
          if (!rd_en && !rd_vld_q) state_q <= StWrite;
        end
        StWrite: begin
          if (insert_q) fill_q <= fill_q + CntW'(1);
          state_q <= StDone;
        end
        StDone: begin
          if (out_load) begin
            res_q.found <= found_q;
            res_q.value <= (found_q && op_q == lkvc_pkg::OpGet) ? hval_q
                                                                : lkvc_pkg::MissValue;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_found_o  = res_q.found;
  assign read_value_o = res_q.value;

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(lkvc_pkg::Entries))
    else $error("fill count beyond slot count");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StScan)
    else $error("accepted beat did not start a scan");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != $past(fill_q) |-> $past(state_q) == StWrite && $past(insert_q))
    else $error("fill count moved outside an insert");
endmodule
`default_nettype wire
